// File: hw/rtl/bchd_pkg.sv
// Package for the button click and hold detector.
// Holds widths, request and register codes, reset values and the sequencer states.
// No dependencies.
package bchd_pkg;

    localparam int TIME_BITS  = 32;
    localparam int COUNT_BITS = 8;
    localparam int CFG_BITS   = 16;
    localparam int STEP_BITS  = $clog2(TIME_BITS);

    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CFG_BITS-1:0]   cfg_t;

    typedef enum logic [1:0] {
        REQ_PRESS   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_POLL    = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_HOLD_BEGIN  = 2'd0,
        CFG_HOLD_PERIOD = 2'd1,
        CFG_CLICK_GAP   = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_idx_t;

    localparam cfg_t HOLD_BEGIN_RST  = CFG_BITS'(500);
    localparam cfg_t HOLD_PERIOD_RST = CFG_BITS'(1000);
    localparam cfg_t CLICK_GAP_RST   = CFG_BITS'(400);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIVIDE,
        ST_APPLY,
        ST_FINISH
    } state_t;

endpackage

// File: hw/rtl/button_click_hold_detector_top.sv
// Button click and hold detector, top level.
// Event sequencer with a shared restoring divider for the hold step count.
// Depends on bchd_pkg.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | req_type, time_ms
//  out     | output    | out_valid/out_stall| clicks, holds, interacting
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Press, bounce and unused codes pass through accept and evaluate only.
// A release of a short press does the same; a poll with no hold under way
// adds the output step, ST_FINISH. Release of a hold runs the divider in
// ST_DIVIDE, then ST_APPLY; a poll while holding adds ST_FINISH after that.
// The quotient loop in ST_DIVIDE makes one quotient bit per cycle.
// Reset returns to released with the register defaults. A result waiting under
// out_stall does not block input; only the next poll's final step waits for it.
module button_click_hold_detector_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              req_type,
    input  logic [31:0]             time_ms,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              clicks,
    output logic [7:0]              holds,
    output logic                    interacting,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [15:0]             cfg_data
);
    import bchd_pkg::*;

    state_t state_reg, state_next;

    // configuration
    cfg_t hold_begin_reg, hold_period_reg, click_gap_reg;

    // captured transaction
    req_t  req_reg;
    time_t now_reg;

    // detector state
    logic   pressed_reg, pressed_next;
    time_t  press_time_reg, press_time_next;
    time_t  release_time_reg, release_time_next;
    count_t click_count_reg, click_count_next;
    count_t hold_count_reg, hold_count_next;
    logic   clicks_pend_reg, clicks_pend_next;
    logic   holds_pend_reg, holds_pend_next;
    count_t clicks_out_reg, clicks_out_next;

    // divider
    time_t                dq_reg, dq_next;
    cfg_t                 rem_reg, rem_next;
    logic [STEP_BITS-1:0] step_reg, step_next;

    // output register
    logic   out_valid_reg, out_valid_next;
    count_t clicks_reg, clicks_next;
    count_t holds_reg, holds_next;
    logic   inter_reg, inter_next;

    logic               in_take;
    logic               out_free;
    time_t              held;
    logic               held_ge;
    logic               div_last;
    logic [CFG_BITS:0]  shifted;
    logic               div_ge;
    count_t             steps;

    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign held     = now_reg - press_time_reg;
    assign held_ge  = held >= TIME_BITS'(hold_begin_reg);
    assign div_last = step_reg == STEP_BITS'(TIME_BITS - 1);
    assign shifted  = {rem_reg, dq_reg[TIME_BITS-1]};
    // a zero divisor gives an all-ones quotient here without special handling
    assign div_ge   = shifted >= {1'b0, hold_period_reg};
    assign steps    = dq_reg[COUNT_BITS-1:0] + COUNT_BITS'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                unique case (req_reg)
                    REQ_RELEASE:
                    begin
                        if (pressed_reg && held_ge)
                            state_next = ST_DIVIDE;
                        else
                            state_next = ST_IDLE;
                    end
                    REQ_POLL:
                    begin
                        if (pressed_reg && held_ge)
                            state_next = ST_DIVIDE;
                        else
                            state_next = ST_FINISH;
                    end
                    REQ_PRESS, REQ_NONE:
                        state_next = ST_IDLE;
                endcase
            end
            ST_DIVIDE:
            begin
                if (div_last)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (req_reg == REQ_POLL)
                    state_next = ST_FINISH;
                else
                    state_next = ST_IDLE;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_stall          = state_reg != ST_IDLE;
        pressed_next      = pressed_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        click_count_next  = click_count_reg;
        hold_count_next   = hold_count_reg;
        clicks_pend_next  = clicks_pend_reg;
        holds_pend_next   = holds_pend_reg;
        clicks_out_next   = clicks_out_reg;
        dq_next           = dq_reg;
        rem_next          = rem_reg;
        step_next         = step_reg;
        out_valid_next    = out_valid_reg && out_stall;
        clicks_next       = clicks_reg;
        holds_next        = holds_reg;
        inter_next        = inter_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EVAL:
            begin
                // divider load, used only when the next state is ST_DIVIDE
                dq_next   = held - TIME_BITS'(hold_begin_reg);
                rem_next  = '0;
                step_next = '0;
                unique case (req_reg)
                    REQ_PRESS:
                    begin
                        if (!pressed_reg)
                        begin
                            press_time_next = now_reg;
                            pressed_next    = 1'b1;
                            hold_count_next = '0;
                            holds_pend_next = 1'b0;
                        end
                    end
                    REQ_RELEASE:
                    begin
                        if (pressed_reg)
                        begin
                            release_time_next = now_reg;
                            pressed_next      = 1'b0;
                            if (!held_ge)
                            begin
                                click_count_next = click_count_reg + COUNT_BITS'(1);
                                clicks_pend_next = 1'b1;
                            end
                        end
                    end
                    REQ_POLL:
                    begin
                        clicks_out_next = '0;
                        if (clicks_pend_reg &&
                            (now_reg - release_time_reg) >= TIME_BITS'(click_gap_reg))
                        begin
                            clicks_out_next  = click_count_reg;
                            click_count_next = '0;
                            clicks_pend_next = 1'b0;
                        end
                    end
                    REQ_NONE:
                    begin
                    end
                endcase
            end
            ST_DIVIDE:
            begin
                dq_next   = {dq_reg[TIME_BITS-2:0], div_ge};
                rem_next  = div_ge ? CFG_BITS'(shifted - {1'b0, hold_period_reg})
                                   : shifted[CFG_BITS-1:0];
                step_next = step_reg + STEP_BITS'(1);
            end
            ST_APPLY:
            begin
                if (steps != hold_count_reg)
                begin
                    hold_count_next = steps;
                    holds_pend_next = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    clicks_next    = clicks_out_reg;
                    holds_next     = holds_pend_reg ? hold_count_reg : '0;
                    inter_next     = pressed_reg || clicks_pend_reg;
                    if (holds_pend_reg && !pressed_reg)
                        hold_count_next = '0;
                    holds_pend_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            hold_begin_reg   <= HOLD_BEGIN_RST;
            hold_period_reg  <= HOLD_PERIOD_RST;
            click_gap_reg    <= CLICK_GAP_RST;
            pressed_reg      <= 1'b0;
            press_time_reg   <= '0;
            release_time_reg <= '0;
            click_count_reg  <= '0;
            hold_count_reg   <= '0;
            clicks_pend_reg  <= 1'b0;
            holds_pend_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pressed_reg      <= pressed_next;
            press_time_reg   <= press_time_next;
            release_time_reg <= release_time_next;
            click_count_reg  <= click_count_next;
            hold_count_reg   <= hold_count_next;
            clicks_pend_reg  <= clicks_pend_next;
            holds_pend_reg   <= holds_pend_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_HOLD_BEGIN:  hold_begin_reg  <= cfg_data;
                    CFG_HOLD_PERIOD: hold_period_reg <= cfg_data;
                    CFG_CLICK_GAP:   click_gap_reg   <= cfg_data;
                    CFG_UNUSED:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg <= req_t'(req_type);
            now_reg <= time_ms;
        end
        clicks_out_reg <= clicks_out_next;
        dq_reg         <= dq_next;
        rem_reg        <= rem_next;
        step_reg       <= step_next;
        clicks_reg     <= clicks_next;
        holds_reg      <= holds_next;
        inter_reg      <= inter_next;
    end

    assign out_valid   = out_valid_reg;
    assign clicks      = clicks_reg;
    assign holds       = holds_reg;
    assign interacting = inter_reg;

endmodule
